// ===== hw/rtl/ppfc_pkg.sv =====
// Shared types, codes and constants of the palette pixel format converter.
package ppfc_pkg;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 22;
  localparam int unsigned FMT_W      = 4;
  localparam int unsigned FP_W       = 22;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OUT_FORMAT   = 2'd0,
    CFG_FRAME_PIXELS = 2'd1
  } cfg_reg_e;

  // Output layout codes.
  typedef enum logic [FMT_W-1:0] {
    FMT_CRCGCB   = 4'd0,
    FMT_CRCGCBDB = 4'd1,
    FMT_RGB24    = 4'd2,
    FMT_RGBA32   = 4'd3,
    FMT_ARGB32   = 4'd4,
    FMT_CBCGCR   = 4'd5,
    FMT_CBCGCRDB = 4'd6,
    FMT_BGR24    = 4'd7,
    FMT_BGRA32   = 4'd8,
    FMT_ABGR32   = 4'd9,
    FMT_GRAY8    = 4'd10,
    FMT_DEPTH8   = 4'd11,
    FMT_INDEX8   = 4'd12
  } fmt_code_e;

  localparam logic [FMT_W-1:0] OUT_FORMAT_RESET   = FMT_RGB24;
  localparam logic [FP_W-1:0]  FRAME_PIXELS_RESET = 22'd76800;

  // Input function codes.
  localparam logic FUNC_PALETTE_WRITE = 1'b0;
  localparam logic FUNC_PIXEL         = 1'b1;

  // Gray weights in Q0.16 and the fixed alpha byte.
  localparam logic [15:0] GRAY_W_R   = 16'd13763;
  localparam logic [15:0] GRAY_W_G   = 16'd47186;
  localparam logic [15:0] GRAY_W_B   = 16'd4588;
  localparam logic [7:0]  ALPHA_BYTE = 8'hFF;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PLANAR,
    KIND_INTERLEAVED,
    KIND_GRAY,
    KIND_INDEX
  } fmt_kind_e;

  // Decoded layout: red, green and blue go to lane_r/g/b (lane or plane number).
  typedef struct packed {
    fmt_kind_e   kind;
    logic        stride4;
    logic [1:0]  lane_r;
    logic [1:0]  lane_g;
    logic [1:0]  lane_b;
    logic        has_alpha;
    logic [1:0]  lane_a;
  } fmt_t;

  function automatic fmt_t fmt_decode(logic [FMT_W-1:0] code);
    fmt_t f;
    f = '{kind: KIND_NONE, stride4: 1'b0, lane_r: 2'd0, lane_g: 2'd0, lane_b: 2'd0,
          has_alpha: 1'b0, lane_a: 2'd0};
    case (code)
      FMT_CRCGCB, FMT_CRCGCBDB: begin
        f.kind = KIND_PLANAR; f.lane_r = 2'd0; f.lane_g = 2'd1; f.lane_b = 2'd2;
      end
      FMT_CBCGCR, FMT_CBCGCRDB: begin
        f.kind = KIND_PLANAR; f.lane_r = 2'd2; f.lane_g = 2'd1; f.lane_b = 2'd0;
      end
      FMT_RGB24: begin
        f.kind = KIND_INTERLEAVED; f.lane_r = 2'd2; f.lane_g = 2'd1; f.lane_b = 2'd0;
      end
      FMT_BGR24: begin
        f.kind = KIND_INTERLEAVED; f.lane_r = 2'd0; f.lane_g = 2'd1; f.lane_b = 2'd2;
      end
      FMT_RGBA32: begin
        f.kind = KIND_INTERLEAVED; f.stride4 = 1'b1; f.has_alpha = 1'b1;
        f.lane_r = 2'd3; f.lane_g = 2'd2; f.lane_b = 2'd1; f.lane_a = 2'd0;
      end
      FMT_ARGB32: begin
        f.kind = KIND_INTERLEAVED; f.stride4 = 1'b1; f.has_alpha = 1'b1;
        f.lane_r = 2'd2; f.lane_g = 2'd1; f.lane_b = 2'd0; f.lane_a = 2'd3;
      end
      FMT_BGRA32: begin
        f.kind = KIND_INTERLEAVED; f.stride4 = 1'b1; f.has_alpha = 1'b1;
        f.lane_r = 2'd1; f.lane_g = 2'd2; f.lane_b = 2'd3; f.lane_a = 2'd0;
      end
      FMT_ABGR32: begin
        f.kind = KIND_INTERLEAVED; f.stride4 = 1'b1; f.has_alpha = 1'b1;
        f.lane_r = 2'd0; f.lane_g = 2'd1; f.lane_b = 2'd2; f.lane_a = 2'd3;
      end
      FMT_GRAY8:  f.kind = KIND_GRAY;
      FMT_INDEX8: f.kind = KIND_INDEX;
      default:    f.kind = KIND_NONE;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/ppfc_if.sv =====
// Stream and configuration channel interfaces of the palette pixel format converter.
interface ppfc_in_if #(
  parameter int unsigned POS_W = 21
);
  logic             valid;
  logic             ready;
  logic             func;
  logic [7:0]       color_index;
  logic [7:0]       red_in;
  logic [7:0]       green_in;
  logic [7:0]       blue_in;
  logic [POS_W-1:0] pixel_position;

  modport source (output valid, func, color_index, red_in, green_in, blue_in,
                  pixel_position, input ready);
  modport sink   (input valid, func, color_index, red_in, green_in, blue_in,
                  pixel_position, output ready);
endinterface

interface ppfc_out_if #(
  parameter int unsigned ADDR_W = 23
);
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] byte_address;
  logic [7:0]        byte_value;
  logic              last_byte;

  modport source (output valid, byte_address, byte_value, last_byte, input ready);
  modport sink   (input valid, byte_address, byte_value, last_byte, output ready);
endinterface

interface ppfc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ppfc_pkg::CFG_IDX_W-1:0]  index;
  logic [ppfc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/palette_pixel_format_converter.sv =====
// Top level of the palette pixel format converter: palette store, lookup and byte sequencer.
// A pixel's palette entry is read into stage 1, and its bytes then go into the byte queue.
// Each pixel makes 1, 3 or 4 byte writes on the byte-wide result port, and the next pixel
// waits in stage 1 while they drain; palette writes and depth-only pixels make none.
// Reset: out_format goes to RGB24, frame_pixels to 76800 and the pipeline empties.
// The palette RAM is not cleared; entries read before they are written hold anything.
module palette_pixel_format_converter #(
  parameter int unsigned MAX_PIXELS_LOG2 = 21,
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppfc_cfg_if.sink    cfg_i,
  ppfc_in_if.sink     pix_i,
  ppfc_out_if.source  byte_o
);
  import ppfc_pkg::*;

  localparam int unsigned POS_W  = MAX_PIXELS_LOG2;
  localparam int unsigned ADDR_W = MAX_PIXELS_LOG2 + 2;
  // Wide enough for 2 * frame_pixels + position and 4 * position + lane.
  localparam int unsigned SUM_W  = (ADDR_W > FP_W + 2) ? ADDR_W : FP_W + 2;
  localparam int unsigned PAL_AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned LANES  = 4;
  localparam int unsigned CNT_W  = $clog2(LANES + 1);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; unknown indexes are dropped.
  // ---------------------------------------------------------------------------
  logic [FMT_W-1:0] out_format_q, out_format_d;
  logic [FP_W-1:0]  frame_pixels_q, frame_pixels_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    out_format_d   = out_format_q;
    frame_pixels_d = frame_pixels_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_OUT_FORMAT:   out_format_d   = cfg_i.data[FMT_W-1:0];
        CFG_FRAME_PIXELS: frame_pixels_d = cfg_i.data[FP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_format_q   <= OUT_FORMAT_RESET;
      frame_pixels_q <= FRAME_PIXELS_RESET;
    end else begin
      out_format_q   <= out_format_d;
      frame_pixels_q <= frame_pixels_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake control. Stage 1 holds a pixel whose palette entry is being read;
  // stage 2 is a small queue of byte writes that drains one transfer per cycle while the port is ready.
  // ---------------------------------------------------------------------------
  logic             s1_valid_q, s1_valid_d;
  logic [7:0]       s1_idx_q;
  logic [POS_W-1:0] s1_pos_q;
  logic [CNT_W-1:0] s2_cnt_q, s2_cnt_d;
  logic [CNT_W-1:0] s1_nbytes;
  logic             in_fire, out_fire, s2_free, s1_adv, s1_load;
  logic [23:0]      pal_rdata;

  assign out_fire = (s2_cnt_q != '0) && byte_o.ready;
  // The queue can take a new pixel when empty or when its final byte leaves now.
  assign s2_free  = (s2_cnt_q == '0) || ((s2_cnt_q == CNT_W'(1)) && byte_o.ready);
  // A pixel that makes no bytes leaves stage 1 without waiting for the queue.
  assign s1_adv   = s1_valid_q && (s2_free || (s1_nbytes == '0));
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = pix_i.valid && pix_i.ready;
  assign s1_load  = in_fire && (pix_i.func == FUNC_PIXEL);

  // Palette store: written by palette transfers, read when a pixel is accepted.
  // Its read data holds while stage 1 is stalled, since no read is issued then.
  ppfc_ram #(
    .WIDTH (24),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (in_fire && (pix_i.func == FUNC_PALETTE_WRITE)),
    .waddr_i (pix_i.color_index[PAL_AW-1:0]),
    .wdata_i ({pix_i.red_in, pix_i.green_in, pix_i.blue_in}),
    .re_i    (s1_load),
    .raddr_i (pix_i.color_index[PAL_AW-1:0]),
    .rdata_o (pal_rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_idx_q <= pix_i.color_index;
      s1_pos_q <= pix_i.pixel_position;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte generation from the looked-up entry. Color layouts write red, green, blue
  // and then alpha; gray and index layouts write one byte. last_byte marks the final one.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] gen_addr [LANES];
  logic [7:0]        gen_val  [LANES];
  logic              gen_last [LANES];

  always_comb begin
    fmt_t        fmt;
    logic [7:0]  ch [3];
    logic [1:0]  lane [3];
    logic [SUM_W-1:0] pos_ext, fp_ext, base, off;
    logic [23:0] gray_sum;

    fmt     = fmt_decode(out_format_q);
    ch[0]   = pal_rdata[23:16];
    ch[1]   = pal_rdata[15:8];
    ch[2]   = pal_rdata[7:0];
    lane[0] = fmt.lane_r;
    lane[1] = fmt.lane_g;
    lane[2] = fmt.lane_b;
    pos_ext = SUM_W'(s1_pos_q);
    fp_ext  = SUM_W'(frame_pixels_q);
    off     = '0;
    base    = fmt.stride4 ? (pos_ext << 2) : ((pos_ext << 1) + pos_ext);
    // The weights sum to 65537, so the full sum stays below 2^24.
    gray_sum = 24'(GRAY_W_R) * 24'(ch[0]) + 24'(GRAY_W_G) * 24'(ch[1])
             + 24'(GRAY_W_B) * 24'(ch[2]);

    s1_nbytes = '0;
    for (int i = 0; i < LANES; i++) begin
      gen_addr[i] = ADDR_W'(pos_ext);
      gen_val[i]  = ALPHA_BYTE;
      gen_last[i] = 1'b0;
    end

    case (fmt.kind)
      KIND_PLANAR: begin
        s1_nbytes = CNT_W'(3);
        for (int c = 0; c < 3; c++) begin
          case (lane[c])
            2'd1:    off = fp_ext;
            2'd2:    off = fp_ext << 1;
            default: off = '0;
          endcase
          gen_addr[c] = ADDR_W'(off + pos_ext);
          gen_val[c]  = ch[c];
        end
        gen_last[2] = 1'b1;
      end
      KIND_INTERLEAVED: begin
        s1_nbytes = fmt.has_alpha ? CNT_W'(4) : CNT_W'(3);
        for (int c = 0; c < 3; c++) begin
          gen_addr[c] = ADDR_W'(base + SUM_W'(lane[c]));
          gen_val[c]  = ch[c];
        end
        gen_last[2] = !fmt.has_alpha;
        gen_addr[3] = ADDR_W'(base + SUM_W'(fmt.lane_a));
        gen_val[3]  = ALPHA_BYTE;
        gen_last[3] = 1'b1;
      end
      KIND_GRAY: begin
        s1_nbytes   = CNT_W'(1);
        gen_val[0]  = gray_sum[23:16];
        gen_last[0] = 1'b1;
      end
      KIND_INDEX: begin
        s1_nbytes   = CNT_W'(1);
        gen_val[0]  = s1_idx_q;
        gen_last[0] = 1'b1;
      end
      default: s1_nbytes = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Byte queue: entry 0 drives the result port and the rest shift down on each
  // transfer, so the payload comes straight from registers.
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] s2_addr_q [LANES];
  logic [7:0]        s2_val_q  [LANES];
  logic              s2_last_q [LANES];
  logic              s2_load;

  assign s2_load = s1_adv && (s1_nbytes != '0);

  always_comb begin
    s2_cnt_d = s2_cnt_q;
    if (s2_load) begin
      s2_cnt_d = s1_nbytes;
    end else if (out_fire) begin
      s2_cnt_d = s2_cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_cnt_q   <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_cnt_q   <= s2_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      for (int i = 0; i < LANES; i++) begin
        s2_addr_q[i] <= gen_addr[i];
        s2_val_q[i]  <= gen_val[i];
        s2_last_q[i] <= gen_last[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < LANES - 1; i++) begin
        s2_addr_q[i] <= s2_addr_q[i+1];
        s2_val_q[i]  <= s2_val_q[i+1];
        s2_last_q[i] <= s2_last_q[i+1];
      end
    end
  end

  assign byte_o.valid        = (s2_cnt_q != '0);
  assign byte_o.byte_address = s2_addr_q[0];
  assign byte_o.byte_value   = s2_val_q[0];
  assign byte_o.last_byte    = s2_last_q[0];

`ifndef SYNTH
  // The queue never holds more writes than one pixel can make.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_cnt_q <= CNT_W'(LANES))
    else $error("byte queue count out of range");

  // The port shows last_byte exactly when one write is left in the queue.
  a_last_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_o.valid |-> (byte_o.last_byte == (s2_cnt_q == CNT_W'(1))))
    else $error("last_byte does not match queue position");

  // A palette read always fills stage 1 on the next cycle.
  a_read_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |=> s1_valid_q)
    else $error("palette read without stage 1 pixel");

  // A pixel stalled in stage 1 blocks new input, keeping the RAM read data intact.
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !pix_i.ready)
    else $error("input accepted while stage 1 stalled");
`endif

endmodule

// ===== hw/rtl/ppfc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ppfc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/ppfc_write_check.sv =====
`timescale 1ns / 100ps
// Byte-write predictor and comparator that watches the converter's three channels.
module ppfc_write_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppfc_cfg_if         cfg_mon,
  ppfc_in_if          pix_mon,
  ppfc_out_if         byte_mon,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);
  import ppfc_pkg::*;

  localparam int unsigned ADDR_W     = 23;
  localparam int unsigned POS_W      = 21;
  localparam int unsigned MAX_PRINTS = 20;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        value;
    logic              last;
  } byte_write_t;

  byte_write_t       expected_writes[$];
  logic [23:0]       palette_copy [256];
  logic [FMT_W-1:0]  layout;
  logic [FP_W-1:0]   plane_size;
  int unsigned       mismatch_count;
  int unsigned       checked_count;

  assign mismatches_o = mismatch_count;
  assign checked_o    = checked_count;

  initial begin
    mismatch_count = 0;
    checked_count  = 0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS) begin
      $display("[%0t] byte write error: %s", $time, msg);
    end
  endtask

  function automatic void queue_write(input logic [63:0] addr, input logic [7:0] value,
                                      input logic last);
    byte_write_t w;
    w.addr  = addr[ADDR_W-1:0];
    w.value = value;
    w.last  = last;
    expected_writes.push_back(w);
  endfunction

  // Works out the byte writes of one pixel from the current layout and palette.
  function automatic void predict_pixel(input logic [7:0] idx, input logic [POS_W-1:0] pos);
    fmt_kind_e   kind;
    logic [1:0]  lane [3];
    logic [1:0]  alpha_lane;
    bit          has_alpha;
    logic [7:0]  chan [3];
    logic [63:0] addr;
    logic [63:0] stride;
    logic [31:0] gray_sum;
    kind       = KIND_NONE;
    has_alpha  = 1'b0;
    alpha_lane = 2'd0;
    lane[0]    = 2'd0;
    lane[1]    = 2'd1;
    lane[2]    = 2'd2;
    chan[0]    = palette_copy[idx][23:16];
    chan[1]    = palette_copy[idx][15:8];
    chan[2]    = palette_copy[idx][7:0];
    case (layout)
      FMT_CRCGCB, FMT_CRCGCBDB: kind = KIND_PLANAR;
      FMT_CBCGCR, FMT_CBCGCRDB: begin
        kind = KIND_PLANAR; lane[0] = 2'd2; lane[2] = 2'd0;
      end
      FMT_RGB24: begin
        kind = KIND_INTERLEAVED; lane[0] = 2'd2; lane[2] = 2'd0;
      end
      FMT_BGR24: kind = KIND_INTERLEAVED;
      FMT_RGBA32: begin
        kind = KIND_INTERLEAVED; has_alpha = 1'b1;
        lane[0] = 2'd3; lane[1] = 2'd2; lane[2] = 2'd1; alpha_lane = 2'd0;
      end
      FMT_ARGB32: begin
        kind = KIND_INTERLEAVED; has_alpha = 1'b1;
        lane[0] = 2'd2; lane[1] = 2'd1; lane[2] = 2'd0; alpha_lane = 2'd3;
      end
      FMT_BGRA32: begin
        kind = KIND_INTERLEAVED; has_alpha = 1'b1;
        lane[0] = 2'd1; lane[1] = 2'd2; lane[2] = 2'd3; alpha_lane = 2'd0;
      end
      FMT_ABGR32: begin
        kind = KIND_INTERLEAVED; has_alpha = 1'b1; alpha_lane = 2'd3;
      end
      FMT_GRAY8:  kind = KIND_GRAY;
      FMT_INDEX8: kind = KIND_INDEX;
      default:    kind = KIND_NONE;
    endcase
    case (kind)
      KIND_PLANAR: begin
        for (int c = 0; c < 3; c++) begin
          addr = 64'(lane[c]) * 64'(plane_size) + 64'(pos);
          queue_write(addr, chan[c], c == 2);
        end
      end
      KIND_INTERLEAVED: begin
        stride = has_alpha ? 64'd4 : 64'd3;
        for (int c = 0; c < 3; c++) begin
          addr = 64'(pos) * stride + 64'(lane[c]);
          queue_write(addr, chan[c], (c == 2) && !has_alpha);
        end
        if (has_alpha) begin
          queue_write(64'(pos) * stride + 64'(alpha_lane), ALPHA_BYTE, 1'b1);
        end
      end
      KIND_GRAY: begin
        gray_sum = 32'(GRAY_W_R) * 32'(chan[0]) + 32'(GRAY_W_G) * 32'(chan[1])
                 + 32'(GRAY_W_B) * 32'(chan[2]);
        queue_write(64'(pos), gray_sum[23:16], 1'b1);
      end
      KIND_INDEX: queue_write(64'(pos), idx, 1'b1);
      default: ;
    endcase
  endfunction

  task automatic compare_write(input logic [ADDR_W-1:0] addr, input logic [7:0] value,
                               input logic last);
    byte_write_t want;
    checked_count++;
    if (expected_writes.size() == 0) begin
      report_mismatch($sformatf("unexpected write addr=%0h value=%0h last=%0b",
                                addr, value, last));
      return;
    end
    want = expected_writes.pop_front();
    if (addr !== want.addr) begin
      report_mismatch($sformatf("address %0h, expected %0h", addr, want.addr));
    end
    if (value !== want.value) begin
      report_mismatch($sformatf("value %0h at %0h, expected %0h", value, want.addr,
                                want.value));
    end
    if (last !== want.last) begin
      report_mismatch($sformatf("last flag %0b at %0h, expected %0b", last, want.addr,
                                want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout     = OUT_FORMAT_RESET;
      plane_size = FRAME_PIXELS_RESET;
      expected_writes.delete();
      pending_o <= 0;
    end else begin
      if (byte_mon.valid && byte_mon.ready) begin
        compare_write(byte_mon.byte_address, byte_mon.byte_value, byte_mon.last_byte);
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_OUT_FORMAT:   layout     = cfg_mon.data[FMT_W-1:0];
          CFG_FRAME_PIXELS: plane_size = cfg_mon.data[FP_W-1:0];
          default: ;
        endcase
      end
      if (pix_mon.valid && pix_mon.ready) begin
        if (pix_mon.func == FUNC_PALETTE_WRITE) begin
          palette_copy[pix_mon.color_index] = {pix_mon.red_in, pix_mon.green_in,
                                               pix_mon.blue_in};
        end else begin
          predict_pixel(pix_mon.color_index, pix_mon.pixel_position);
        end
      end
      pending_o <= expected_writes.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Top of the converter testbench: stimulus, register phases, output stalls and the verdict.
module tb;
  import ppfc_pkg::*;

  localparam int unsigned POS_W           = 21;
  localparam int unsigned ADDR_W          = 23;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SWEEP_PHASES    = 16;
  localparam int unsigned MIXED_PHASES    = 12;
  localparam int unsigned SWEEP_ITEMS     = 12;
  localparam int unsigned MIXED_ITEMS     = 13;
  localparam int unsigned TIMEOUT_NS      = 1000000;

  localparam logic [POS_W-1:0] POS_MAX       = '1;
  localparam logic [FP_W-1:0]  FRAME_MIN     = 22'd1;
  localparam logic [FP_W-1:0]  FRAME_MAX     = 22'd2097152;
  // All ones makes the third plane's addresses run past the address width, so they wrap.
  localparam logic [FP_W-1:0]  FRAME_WRAP    = '1;

  logic clk_i;
  logic rst_ni;

  ppfc_cfg_if                  cfg_ch ();
  ppfc_in_if  #(.POS_W(POS_W))   pix_ch ();
  ppfc_out_if #(.ADDR_W(ADDR_W)) byte_ch ();

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  // Stimulus-side bookkeeping. Only palette slots already written are used by pixels,
  // since the palette RAM holds garbage until an entry is written.
  bit              quiet_mode;
  bit              hold_off_req;
  logic [FP_W-1:0] frame_now;
  logic [7:0]      written_slots[$];
  bit              slot_written [256];
  int unsigned     pixel_count;
  int unsigned     palette_count;
  int unsigned     setting_count;

  palette_pixel_format_converter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .pix_i  (pix_ch),
    .byte_o (byte_ch)
  );

  ppfc_write_check write_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_ch),
    .pix_mon      (pix_ch),
    .byte_mon     (byte_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Gap lengths: mostly none or short, now and then a long one. Quiet mode turns all
  // gaps off so that some stretches run at full rate on both sides.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Positions lean toward the frame's corners, the end of the position range and
  // values past the frame, which the block does not check.
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned limit;
    limit = (frame_now > FRAME_MAX) ? 32'(POS_MAX) : 32'(frame_now) - 1;
    if (limit > 32'(POS_MAX)) limit = 32'(POS_MAX);
    case ($urandom_range(9))
      0:       return '0;
      1:       return POS_MAX;
      2:       return POS_W'(limit);
      3:       return POS_W'($urandom());
      default: return POS_W'($urandom_range(limit));
    endcase
  endfunction

  // Offers one item and returns at the edge where its transfer happens. With no gap,
  // valid simply stays high and only the payload changes.
  task automatic offer_item(input logic func, input logic [7:0] idx,
                            input logic [23:0] rgb, input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_ch.valid          <= 1'b1;
    pix_ch.func           <= func;
    pix_ch.color_index    <= idx;
    pix_ch.red_in         <= rgb[23:16];
    pix_ch.green_in       <= rgb[15:8];
    pix_ch.blue_in        <= rgb[7:0];
    pix_ch.pixel_position <= pos;
    do @(posedge clk_i); while (!pix_ch.ready);
    if (func == FUNC_PALETTE_WRITE) begin
      palette_count++;
      if (!slot_written[idx]) begin
        slot_written[idx] = 1'b1;
        written_slots.push_back(idx);
      end
    end else begin
      pixel_count++;
    end
  endtask

  // A pixel with a random but already written palette index, or a palette update.
  task automatic offer_random_item();
    logic [7:0] idx;
    if ($urandom_range(99) < 25) begin
      offer_item(FUNC_PALETTE_WRITE, 8'($urandom()), 24'($urandom()), POS_W'($urandom()));
    end else begin
      idx = written_slots[$urandom_range(written_slots.size() - 1)];
      offer_item(FUNC_PIXEL, idx, 24'($urandom()), pick_position());
    end
  endtask

  // Lowers valid, then waits until every predicted write has come out and DRAIN_CYCLES
  // more, so that pixels that produce no writes leave the pipeline.
  task automatic wait_drained();
    pix_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes both registers back to back; valid stays high across the two transfers.
  task automatic apply_setting(input logic [FMT_W-1:0] fmt, input logic [FP_W-1:0] fp);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_OUT_FORMAT;
    cfg_ch.data  <= CFG_DATA_W'(fmt);
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_FRAME_PIXELS;
    cfg_ch.data  <= CFG_DATA_W'(fp);
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    frame_now = fp;
    setting_count++;
  endtask

  // Output side: open stretches of random length broken by stalls, plus one long
  // hold-off on request so the converter backs up and stalls its input.
  initial begin
    int unsigned open_len;
    int unsigned stall_len;
    byte_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        byte_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        open_len = $urandom_range(20, 1);
        byte_ch.ready <= 1'b1;
        repeat (open_len) @(posedge clk_i);
        stall_len = pick_gap();
        if (stall_len != 0) begin
          byte_ch.ready <= 1'b0;
          repeat (stall_len) @(posedge clk_i);
        end
      end
    end
  end

  // Hard limit well beyond the slowest correct run.
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d byte writes still outstanding", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned items;
    logic [FP_W-1:0] fp;
    rst_ni                 = 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= CFG_OUT_FORMAT;
    cfg_ch.data           <= '0;
    pix_ch.valid          <= 1'b0;
    pix_ch.func           <= FUNC_PALETTE_WRITE;
    pix_ch.color_index    <= '0;
    pix_ch.red_in         <= '0;
    pix_ch.green_in       <= '0;
    pix_ch.blue_in        <= '0;
    pix_ch.pixel_position <= '0;
    quiet_mode             = 1'b0;
    hold_off_req           = 1'b0;
    frame_now              = FRAME_PIXELS_RESET;
    pixel_count            = 0;
    palette_count          = 0;
    setting_count          = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset setting (RGB24, 76800 pixels). Black and white
    // entries cover the gray extremes; the two mixed entries toggle every color and
    // index bit. Pixels then hit position zero, the end of the position range, the
    // last pixel of the frame and the first position past it.
    offer_item(FUNC_PALETTE_WRITE, 8'h00, 24'h000000, '0);
    offer_item(FUNC_PALETTE_WRITE, 8'hFF, 24'hFFFFFF, POS_MAX);
    offer_item(FUNC_PALETTE_WRITE, 8'h5A, 24'hFF0055, '0);
    offer_item(FUNC_PALETTE_WRITE, 8'hA5, 24'h00FFAA, POS_MAX);
    offer_item(FUNC_PIXEL, 8'h00, 24'h000000, '0);
    offer_item(FUNC_PIXEL, 8'hFF, 24'hFFFFFF, POS_MAX);
    offer_item(FUNC_PIXEL, 8'h5A, 24'h000000, POS_W'(FRAME_PIXELS_RESET - 1));
    offer_item(FUNC_PIXEL, 8'hA5, 24'h000000, POS_W'(FRAME_PIXELS_RESET));

    // Sweep through every format code, the unused ones included, pairing the planar
    // layouts with the smallest frame, the largest one and the wrapping size.
    for (int p = 0; p < int'(SWEEP_PHASES + MIXED_PHASES); p++) begin
      wait_drained();
      if (p < int'(SWEEP_PHASES)) begin
        case (p % 4)
          0:       fp = FRAME_MIN;
          1:       fp = FRAME_WRAP;
          2:       fp = FRAME_MAX;
          default: fp = FRAME_PIXELS_RESET;
        endcase
        apply_setting(FMT_W'(p), fp);
        items = SWEEP_ITEMS;
      end else begin
        fp = ($urandom_range(3) == 0) ? FP_W'($urandom_range(64, 1))
                                      : FP_W'($urandom_range(FRAME_MAX, 1));
        apply_setting(FMT_W'($urandom_range(FMT_INDEX8)), fp);
        items = MIXED_ITEMS;
      end
      // Two phases run with the output held off for a long stretch while the input
      // keeps offering at full rate; a few more run with no idling at all.
      quiet_mode = (p % 7 == 2) || (p == 3) || (p == 20);
      if (p == 3 || p == 20) begin
        hold_off_req = 1'b1;
        items = items * 2;
      end
      repeat (items) offer_random_item();
    end
    wait_drained();

    $display("run covered %0d pixels and %0d palette updates over %0d register settings",
             pixel_count, palette_count, setting_count);
    $display("%0d byte writes compared, %0d errors, %0d left waiting",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
